// ===== design/bmd_pkg.sv =====
`default_nettype none

package bmd_pkg;

    // Build-time defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_RADIUS = 15;

    // Frame height limit and the row counter widths that follow from it.
    localparam int MAX_HEIGHT = 4096;
    localparam int HGT_W      = 12;
    localparam int ROW_W      = 13;

    // Configuration port.
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int RADIUS_RAW_W = 4;

    localparam int RESET_FRAME_WIDTH  = 1920;
    localparam int RESET_FRAME_HEIGHT = 1080;
    localparam int RESET_RADIUS       = 1;

    // Words held between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_RADIUS       = 2'd2
    } cfg_reg_t;

    // Per-word control handed from the front part to the back part.
    typedef struct packed {
        logic emit;
        logic last;
        logic hbit;
    } bmd_flags_t;

endpackage

`default_nettype wire

// ===== design/bmd_front.sv =====
`default_nettype none

module bmd_front #(
    parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = bmd_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [bmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmd_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              cmd,
    input  wire logic                              pixel,
    input  wire logic                              q_full,
    output logic                                   push,
    output logic [$clog2(MAX_WIDTH)-1:0]           push_col,
    output logic [$clog2(MAX_RADIUS+1)-1:0]        push_jlo,
    output logic [$clog2(MAX_RADIUS+1):0]          push_jhi,
    output bmd_pkg::bmd_flags_t                    push_flags
);
    import bmd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int WIN_W  = 2 * MAX_RADIUS + 1;
    localparam int SUM_W  = ((COL_W > RAD_W) ? COL_W : RAD_W) + 2;
    localparam int WCMP_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int RCMP_W = (RAD_W > RADIUS_RAW_W) ? RAD_W : RADIUS_RAW_W;

    localparam int W_RST = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
    localparam int R_RST = (RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RESET_RADIUS;

    // Effective configuration: width and height are kept as value minus one.
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [HGT_W-1:0] h_m1_reg, h_m1_next;
    logic [RAD_W-1:0] r_reg, r_next;

    logic             active_reg, active_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [RAD_W-1:0] lead_reg, lead_next;
    logic [COL_W-1:0] t_col_reg, t_col_next;
    logic [ROW_W-1:0] t_row_reg, t_row_next;

    logic [WCMP_W-1:0] fw_ext;
    logic [RCMP_W-1:0] raw_r;
    logic [COL_W-1:0]  w_m1_cfg;
    logic [HGT_W-1:0]  h_m1_cfg;
    logic [RAD_W-1:0]  r_cfg;

    logic             accept;
    logic             ignore;
    logic             bit_in;
    logic [WIN_W-1:0] win_shift;
    logic             produce;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] w_m1_ext;
    logic [RAD_W:0]   r2;
    logic [RAD_W-1:0] klo;
    logic [RAD_W:0]   khi;
    logic [WIN_W-1:0] hmask;
    logic             hbit;
    logic [ROW_W-1:0] h_m1_row;
    logic [RAD_W-1:0] jlo;
    logic [RAD_W:0]   jhi;
    logic             emit;
    logic             last;
    logic             restart;

    // Clamp register writes to the supported ranges.
    always_comb
    begin
        fw_ext = WCMP_W'(cfg_data);
        if (fw_ext == '0)
            w_m1_cfg = '0;
        else if (fw_ext > WCMP_W'(MAX_WIDTH))
            w_m1_cfg = COL_W'(MAX_WIDTH - 1);
        else
            w_m1_cfg = COL_W'(fw_ext - WCMP_W'(1));

        if (cfg_data == '0)
            h_m1_cfg = '0;
        else if (cfg_data > CFG_W'(MAX_HEIGHT))
            h_m1_cfg = HGT_W'(MAX_HEIGHT - 1);
        else
            h_m1_cfg = HGT_W'(cfg_data - CFG_W'(1));

        raw_r = RCMP_W'(cfg_data[RADIUS_RAW_W-1:0]);
        if (raw_r > RCMP_W'(MAX_RADIUS))
            r_cfg = RAD_W'(MAX_RADIUS);
        else
            r_cfg = RAD_W'(raw_r);
    end

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    // A flush word before the first pixel of a frame is dropped.
    assign ignore    = cmd && !active_reg;
    assign h_m1_row  = ROW_W'(h_m1_reg);
    assign bit_in    = !cmd && pixel && (in_row_reg <= h_m1_row);
    assign win_shift = {win_reg[WIN_W-2:0], bit_in};
    // The trailing position t = q - r exists once r words have gone in.
    assign produce   = (lead_reg == r_reg);

    // Horizontal pass: window bit k holds column t_col + r - k of the same row.
    assign col_sum  = SUM_W'(t_col_reg) + SUM_W'(r_reg);
    assign w_m1_ext = SUM_W'(w_m1_reg);
    assign r2       = {r_reg, 1'b0};
    assign klo      = (col_sum > w_m1_ext) ? RAD_W'(col_sum - w_m1_ext) : '0;
    assign khi      = (col_sum < SUM_W'(r2)) ? (RAD_W + 1)'(col_sum) : r2;

    always_comb
    begin
        for (int k = 0; k < WIN_W; k++)
        begin
            hmask[k] = ((RAD_W + 1)'(k) >= (RAD_W + 1)'(klo)) && ((RAD_W + 1)'(k) <= khi);
        end
    end

    assign hbit = |(win_shift & hmask);

    // Vertical bounds: history bit j is row t_row - j, limited to rows in the frame.
    assign jlo  = (t_row_reg > h_m1_row) ? RAD_W'(t_row_reg - h_m1_row) : '0;
    assign jhi  = (t_row_reg < ROW_W'(r2)) ? (RAD_W + 1)'(t_row_reg) : r2;
    assign emit = (t_row_reg >= ROW_W'(r_reg));
    assign last = emit && (t_col_reg == w_m1_reg) &&
                  (t_row_reg == h_m1_row + ROW_W'(r_reg));

    assign push       = accept && !ignore && produce;
    assign push_col   = t_col_reg;
    assign push_jlo   = jlo;
    assign push_jhi   = jhi;
    assign push_flags = '{emit: emit, last: last, hbit: hbit};

    always_comb
    begin
        w_m1_next   = w_m1_reg;
        h_m1_next   = h_m1_reg;
        r_next      = r_reg;
        active_next = active_reg;
        win_next    = win_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        t_col_next  = t_col_reg;
        t_row_next  = t_row_reg;
        restart     = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    w_m1_next = w_m1_cfg;
                    restart   = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    h_m1_next = h_m1_cfg;
                    restart   = 1'b1;
                end
                REG_RADIUS:
                begin
                    r_next  = r_cfg;
                    restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && !ignore)
        begin
            active_next = 1'b1;
            win_next    = win_shift;
            if (in_col_reg == w_m1_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end

            if (produce)
            begin
                if (t_col_reg == w_m1_reg)
                begin
                    t_col_next = '0;
                    t_row_next = t_row_reg + 1'b1;
                end
                else
                begin
                    t_col_next = t_col_reg + 1'b1;
                end
                // The bottom-right result closes the frame.
                restart = last;
            end
            else
            begin
                lead_next = lead_reg + 1'b1;
            end
        end

        if (restart)
        begin
            active_next = 1'b0;
            win_next    = '0;
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            t_col_next  = '0;
            t_row_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg   <= COL_W'(W_RST - 1);
            h_m1_reg   <= HGT_W'(RESET_FRAME_HEIGHT - 1);
            r_reg      <= RAD_W'(R_RST);
            active_reg <= 1'b0;
            win_reg    <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            lead_reg   <= '0;
            t_col_reg  <= '0;
            t_row_reg  <= '0;
        end
        else
        begin
            w_m1_reg   <= w_m1_next;
            h_m1_reg   <= h_m1_next;
            r_reg      <= r_next;
            active_reg <= active_next;
            win_reg    <= win_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            t_col_reg  <= t_col_next;
            t_row_reg  <= t_row_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bmd_queue.sv =====
`default_nettype none

module bmd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = bmd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output logic [DATA_W-1:0]      pop_data
);
    import bmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (PTR_W + 1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/bmd_back.sv =====
`default_nettype none

module bmd_back #(
    parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = bmd_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    output logic                                   pop,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      q_col,
    input  wire logic [$clog2(MAX_RADIUS+1)-1:0]   q_jlo,
    input  wire logic [$clog2(MAX_RADIUS+1):0]     q_jhi,
    input  wire bmd_pkg::bmd_flags_t               q_flags,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_pixel,
    output logic                                   last_of_frame
);
    import bmd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int WIN_W  = 2 * MAX_RADIUS + 1;
    localparam int HIST_W = 2 * MAX_RADIUS;

    // Per column, the horizontal results of the last 2*MAX_RADIUS rows, newest in bit 0.
    logic [HIST_W-1:0] hist_mem [MAX_WIDTH];

    logic              s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]  s1_col_reg;
    logic [RAD_W-1:0]  s1_jlo_reg;
    logic [RAD_W:0]    s1_jhi_reg;
    bmd_flags_t        s1_flags_reg;
    logic [HIST_W-1:0] rd_data_reg;
    logic              fwd_reg, fwd_next;
    logic [HIST_W-1:0] fwd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_pixel_reg;
    logic              out_last_reg;

    logic [HIST_W-1:0] hist_old;
    logic [WIN_W-1:0]  full_col;
    logic [HIST_W-1:0] hist_new;
    logic [WIN_W-1:0]  vmask;
    logic              vbit;
    logic              out_free;
    logic              s1_fire;

    // When the word just read hits the column being written back, the stale
    // memory data is replaced by the value written in that same cycle.
    assign hist_old = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign full_col = {hist_old, s1_flags_reg.hbit};
    assign hist_new = full_col[HIST_W-1:0];

    always_comb
    begin
        for (int k = 0; k < WIN_W; k++)
        begin
            vmask[k] = ((RAD_W + 1)'(k) >= (RAD_W + 1)'(s1_jlo_reg)) &&
                       ((RAD_W + 1)'(k) <= s1_jhi_reg);
        end
    end

    assign vbit     = |(full_col & vmask);
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_flags_reg.emit || out_free);
    assign pop      = q_valid && (!s1_valid_reg || s1_fire);

    assign out_valid     = out_valid_reg;
    assign out_pixel     = out_pixel_reg;
    assign last_of_frame = out_last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        fwd_next      = fwd_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
            fwd_next      = s1_fire && (q_col == s1_col_reg);
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_flags_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_col_reg   <= q_col;
            s1_jlo_reg   <= q_jlo;
            s1_jhi_reg   <= q_jhi;
            s1_flags_reg <= q_flags;
            fwd_data_reg <= hist_new;
        end
        if (s1_fire && s1_flags_reg.emit)
        begin
            out_pixel_reg <= vbit;
            out_last_reg  <= s1_flags_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            hist_mem[s1_col_reg] <= hist_new;
        if (pop)
            rd_data_reg <= hist_mem[q_col];
    end

endmodule

`default_nettype wire

// ===== design/binary_mask_dilation_unit.sv =====
// The result for pixel (x,y) is offered on out_valid once the word at position y*width + x +
// radius*width + radius has passed the queue, read stage and output register. Throughput: one
// word per clock while out_ready keeps up, set by the single column-history read-modify-write
// per word. Reset (rst_n low, asynchronous) clears the stream position, window and handshake
// state and loads width 1920, height 1080, radius 1; the column history is not cleared.
`default_nettype none

module binary_mask_dilation_unit #(
    parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = bmd_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bmd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic                          pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_pixel,
    output logic                               last_of_frame
);
    import bmd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int FLG_W  = $bits(bmd_flags_t);
    localparam int DATA_W = COL_W + RAD_W + (RAD_W + 1) + FLG_W;

    logic              q_full;
    logic              push;
    logic [COL_W-1:0]  push_col;
    logic [RAD_W-1:0]  push_jlo;
    logic [RAD_W:0]    push_jhi;
    bmd_flags_t        push_flags;
    logic              pop;
    logic              q_valid;
    logic [DATA_W-1:0] push_data;
    logic [DATA_W-1:0] pop_data;
    logic [COL_W-1:0]  q_col;
    logic [RAD_W-1:0]  q_jlo;
    logic [RAD_W:0]    q_jhi;
    bmd_flags_t        q_flags;

    bmd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pixel      (pixel),
        .q_full     (q_full),
        .push       (push),
        .push_col   (push_col),
        .push_jlo   (push_jlo),
        .push_jhi   (push_jhi),
        .push_flags (push_flags)
    );

    assign push_data = {push_col, push_jlo, push_jhi, push_flags};

    bmd_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    assign {q_col, q_jlo, q_jhi, q_flags} = pop_data;

    bmd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop           (pop),
        .q_col         (q_col),
        .q_jlo         (q_jlo),
        .q_jhi         (q_jhi),
        .q_flags       (q_flags),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_pixel     (out_pixel),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

// ===== design/bmd_checker.sv =====
`default_nettype none

module bmd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_write,
    input wire logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [bmd_pkg::CFG_W-1:0]     cfg_data,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          cmd,
    input wire logic                          pixel,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          out_pixel,
    input wire logic                          last_of_frame
);
    import bmd_pkg::*;

    localparam int CREDIT_W = 16;

    // Words accepted minus results taken; it sticks once it saturates.
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic                in_acc;
    logic                out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (credit_reg != '1)
        begin
            if (in_acc && !out_acc)
                credit_next = credit_reg + 1'b1;
            else if (out_acc && !in_acc && credit_reg != '0)
                credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

    // No result is offered while reset is held.
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // The input side is open right after reset.
    a_ready_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> in_ready)
        else $error("input not ready after reset");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(last_of_frame))
        else $error("stalled result changed");

    // Every result is owed to a word accepted on an earlier edge.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> credit_reg != '0)
        else $error("result without an earlier input word");

endmodule

bind binary_mask_dilation_unit bmd_checker u_bmd_checker (.*);

`default_nettype wire

// ===== tb/bmd_tb_pkg.sv =====
package bmd_tb_pkg;

    // Meaning of the cmd field of an input word.
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } mask_cmd_t;

endpackage

// ===== tb/bmd_dilation_checker.sv =====
module bmd_dilation_checker
    import bmd_pkg::*;
    import bmd_tb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 cmd,
    input  logic                 pixel,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 out_pixel,
    input  logic                 last_of_frame,
    output int                   mismatches,
    output int                   pending_results,
    output int                   words_taken,
    output int                   results_seen,
    output int                   frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic pix;
        logic last;
    } dilated_t;

    dilated_t dilated_q[$];

    logic [CFG_W-1:0]          frame_width_reg;
    logic [CFG_W-1:0]          frame_height_reg;
    logic [RADIUS_RAW_W-1:0]   radius_reg;
    logic [2*MAX_RADIUS-1:0]   col_hist [0:MAX_WIDTH-1];
    logic [2*MAX_RADIUS:0]     window;
    int unsigned               in_col, in_row, out_col, out_row;
    int                        err_count, taken, seen, frames;

    function automatic int unsigned active_width();
        if (frame_width_reg == 0) return 1;
        return (frame_width_reg > MAX_WIDTH) ? MAX_WIDTH : frame_width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (frame_height_reg == 0) return 1;
        return (frame_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : frame_height_reg;
    endfunction

    function automatic int unsigned active_radius();
        return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    endfunction

    // True if any bit from lo to hi, both included, is set.
    function automatic logic span_has_ink(input logic [63:0] v, input int unsigned lo,
                                          input int unsigned hi);
        logic [63:0] m;
        if (lo > hi || lo > 63) return 1'b0;
        m = (64'd1 << (hi - lo + 1)) - 64'd1;
        return ((v >> lo) & m) != 64'd0;
    endfunction

    task automatic restart_stream();
        window  = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advances the dilation state by one accepted word and queues the result it releases.
    task automatic dilate_word(input logic c, input logic p);
        int unsigned w, h, r, q, t, tc, tr, klo, khi, jlo, jhi;
        logic        hb, vb, lst;
        logic [2*MAX_RADIUS:0] full;
        dilated_t    res;
        w = active_width();
        h = active_height();
        r = active_radius();
        // A flush with no frame started is dropped.
        if (c == CMD_FLUSH && in_col == 0 && in_row == 0) return;
        taken++;
        q = in_row * w + in_col;
        window = {window[2*MAX_RADIUS-1:0], (c == CMD_PIXEL && in_row < h) ? p : 1'b0};
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (q < r) return;
        t  = q - r;
        tc = t % w;
        tr = t / w;
        // Window bit k holds column tc + r - k; clip to the row.
        klo = (tc + r > w - 1) ? tc + r - (w - 1) : 0;
        khi = (tc + r < 2 * r) ? tc + r : 2 * r;
        hb  = span_has_ink(window, klo, khi);
        // Bit j of full holds row tr - j of this column; clip to the frame.
        full = {col_hist[tc], hb};
        col_hist[tc] = full[2*MAX_RADIUS-1:0];
        jlo = (tr > h - 1) ? tr - (h - 1) : 0;
        jhi = (tr < 2 * r) ? tr : 2 * r;
        vb  = span_has_ink(full, jlo, jhi);
        if (tr < r) return;
        lst = (out_col == w - 1 && out_row == h - 1);
        res = '{pix: vb, last: lst};
        dilated_q.insert(dilated_q.size(), res);
        if (lst) begin
            restart_stream();
        end
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  = CFG_W'(RESET_FRAME_WIDTH);
            frame_height_reg = CFG_W'(RESET_FRAME_HEIGHT);
            radius_reg       = RADIUS_RAW_W'(RESET_RADIUS);
            restart_stream();
            for (int i = 0; i < MAX_WIDTH; i++) col_hist[i] = '0;
            dilated_q.delete();
            err_count = 0;
            taken     = 0;
            seen      = 0;
            frames    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen++;
                if (dilated_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d (pixel %0b, last %0b) not expected",
                                              seen, out_pixel, last_of_frame));
                end
                else
                begin
                    if (out_pixel !== dilated_q[0].pix)
                        report_mismatch($sformatf("result %0d out_pixel expected %0b got %0b",
                                                  seen, dilated_q[0].pix, out_pixel));
                    if (last_of_frame !== dilated_q[0].last)
                        report_mismatch($sformatf("result %0d last_of_frame expected %0b got %0b",
                                                  seen, dilated_q[0].last, last_of_frame));
                    if (dilated_q[0].last) frames++;
                    void'(dilated_q.pop_front());
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        frame_width_reg = cfg_data;
                        restart_stream();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        frame_height_reg = cfg_data;
                        restart_stream();
                    end
                    REG_RADIUS:
                    begin
                        radius_reg = cfg_data[RADIUS_RAW_W-1:0];
                        restart_stream();
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready) dilate_word(cmd, pixel);
        end
        mismatches      <= err_count;
        pending_results <= dilated_q.size();
        words_taken     <= taken;
        results_seen    <= seen;
        frames_seen     <= frames;
    end

endmodule

// ===== tb/tb_binary_mask_dilation_unit.sv =====
module tb_binary_mask_dilation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bmd_pkg::*;
    import bmd_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_WORDS   = 800;
    localparam int LONG_RUN_WORDS = 48;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 cmd       = 1'b0;
    logic                 pixel     = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_pixel;
    logic                 last_of_frame;

    int mismatches, pending_results, words_taken, results_seen, frames_seen;
    int cycle_count   = 0;
    int words_sent    = 0;
    int settings_used = 0;

    bit send_gaps_on   = 1'b1;
    bit sink_stalls_on = 1'b1;

    // Effective frame geometry, tracked only to shape whole frames.
    int unsigned cur_w = RESET_FRAME_WIDTH;
    int unsigned cur_h = RESET_FRAME_HEIGHT;
    int unsigned cur_r = RESET_RADIUS;

    binary_mask_dilation_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_pixel     (out_pixel),
        .last_of_frame (last_of_frame)
    );

    bmd_dilation_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_pixel       (out_pixel),
        .last_of_frame   (last_of_frame),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .words_taken     (words_taken),
        .results_seen    (results_seen),
        .frames_seen     (frames_seen)
    );

    always #1 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[binary_mask_dilation_unit] ERROR");
        $finish;
    end

    // Result side: a random stall before each word is taken.
    initial
    begin : result_sink
        int unsigned stall;
        forever
        begin
            stall = sink_stalls_on ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_word(input mask_cmd_t c, input logic p);
        int unsigned gap;
        gap = send_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        pixel    <= p;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Stops sending until every queued result is out and the pipeline has emptied.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input bit do_w, input logic [CFG_W-1:0] w_raw,
                             input bit do_h, input logic [CFG_W-1:0] h_raw,
                             input bit do_r, input logic [CFG_W-1:0] r_data);
        if (do_w)
        begin
            put_reg(REG_FRAME_WIDTH, w_raw);
            cur_w = (w_raw == 0) ? 1 : ((w_raw > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_raw);
        end
        if (do_h)
        begin
            put_reg(REG_FRAME_HEIGHT, h_raw);
            cur_h = (h_raw == 0) ? 1 : ((h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw);
        end
        if (do_r)
        begin
            put_reg(REG_RADIUS, r_data);
            cur_r = r_data[RADIUS_RAW_W-1:0];
            if (cur_r > DEF_MAX_RADIUS) cur_r = DEF_MAX_RADIUS;
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // One frame of pixels plus the flush words that push out its last rows.
    task automatic send_frame(input int unsigned ink_pct, input bit noisy, input bit abandon);
        int unsigned n_pix, n_all, k, stop_at, pause_at;
        mask_cmd_t   c;
        n_pix    = cur_w * cur_h;
        n_all    = n_pix + cur_r * cur_w + cur_r;
        stop_at  = abandon ? $urandom_range(0, n_all - 1) : n_all;
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_all - 1) : n_all;
        for (k = 0; k < stop_at; k++)
        begin
            if (k == pause_at) drain();
            c = CMD_FLUSH;
            if (k < n_pix) c = CMD_PIXEL;
            // Flushes inside the frame and pixels in the trailing part, never on the
            // first word, where a flush would just be dropped.
            if (noisy && k > 0 && $urandom_range(0, 9) == 0)
            begin
                if (c == CMD_PIXEL) c = CMD_FLUSH;
                else c = CMD_PIXEL;
            end
            send_word(c, $urandom_range(0, 99) < ink_pct);
        end
    endtask

    // The opening part of a frame too large to send whole; the next register
    // write abandons it.
    task automatic send_run(input int unsigned n_words, input int unsigned ink_pct,
                            input bit noisy);
        int unsigned k;
        mask_cmd_t   c;
        for (k = 0; k < n_words; k++)
        begin
            c = CMD_PIXEL;
            if (noisy && k > 0 && $urandom_range(0, 9) == 0) c = CMD_FLUSH;
            send_word(c, $urandom_range(0, 99) < ink_pct);
        end
    endtask

    initial
    begin
        int unsigned     k, ph, ink;
        bit [2:0]        pick;
        logic [CFG_W-1:0] w_raw, h_raw, r_data;
        mask_cmd_t       c;

        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: a short burst that stays inside the first row delay,
        // so no result may come out yet.
        send_word(CMD_FLUSH, 1'b1);
        for (k = 0; k < 40; k++)
            send_word(CMD_PIXEL, $urandom_range(0, 99) < 30);
        drain();

        // 3x3 at radius 1: ink on the diagonal, a flush inside the frame and a pixel
        // during the trailing words whose bit must be dropped.
        put_reg(REG_NONE, CFG_W'($urandom));
        configure(1'b1, 3, 1'b1, 3, 1'b1, 1);
        send_word(CMD_FLUSH, 1'b1);
        for (k = 0; k < 9; k++)
        begin
            c = CMD_PIXEL;
            if (k == 2) c = CMD_FLUSH;
            send_word(c, k == 0 || k == 4 || k == 8);
        end
        for (k = 0; k < 4; k++)
        begin
            c = CMD_FLUSH;
            if (k == 0) c = CMD_PIXEL;
            send_word(c, 1'b1);
        end
        drain();

        // Radius 0 passes the mask through; the flush after the frame is idle.
        configure(1'b1, 2, 1'b1, 2, 1'b1, 0);
        for (k = 0; k < 4; k++) send_word(CMD_PIXEL, k == 0 || k == 3);
        send_word(CMD_FLUSH, 1'b0);

        ph = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            drain();
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            case (ph)
                1:
                begin
                    configure(1'b1, DEF_MAX_WIDTH, 1'b1, 2, 1'b1, 0);
                    send_run(LONG_RUN_WORDS, 3, 1'b0);
                end
                3:
                begin
                    configure(1'b1, 1, 1'b1, {CFG_W{1'b1}}, 1'b1, {CFG_W{1'b1}});
                    send_run(LONG_RUN_WORDS, 20, 1'b0);
                end
                5:
                begin
                    configure(1'b1, {CFG_W{1'b1}}, 1'b1, 0, 1'b1, 0);
                    send_run(LONG_RUN_WORDS, 50, 1'b1);
                end
                default:
                begin
                    pick = $urandom_range(1, 7);
                    case ($urandom_range(0, 9))
                        0:       w_raw = 0;
                        1:       w_raw = $urandom_range(9, 24);
                        default: w_raw = $urandom_range(1, 8);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       h_raw = 0;
                        1:       h_raw = $urandom_range(6, 9);
                        default: h_raw = $urandom_range(1, 4);
                    endcase
                    r_data = $urandom;
                    if ($urandom_range(0, 4) == 0)
                        r_data[RADIUS_RAW_W-1:0] = $urandom_range(4, 15);
                    else
                        r_data[RADIUS_RAW_W-1:0] = $urandom_range(0, 3);
                    configure(pick[0], w_raw, pick[1], h_raw, pick[2], r_data);
                    for (k = $urandom_range(1, 3); k > 0; k--)
                    begin
                        if ($urandom_range(0, 3) == 0) send_word(CMD_FLUSH, $urandom_range(0, 1));
                        case ($urandom_range(0, 5))
                            0:       ink = 0;
                            1:       ink = 100;
                            default: ink = $urandom_range(5, 95);
                        endcase
                        send_frame(ink, $urandom_range(0, 3) != 0,
                                   k == 1 && $urandom_range(0, 7) == 0);
                    end
                end
            endcase
            ph++;
        end

        drain();
        $display("Covered %0d words, %0d dilated results and %0d whole frames over %0d settings,",
                 words_taken, results_seen, frames_seen, settings_used);
        $display("from 1x1 frames to clamped 4096-wide and 4096-tall geometries, radius 0 to 15.");
        if (mismatches == 0 && pending_results == 0)
            $display("[binary_mask_dilation_unit] OK");
        else
            $display("[binary_mask_dilation_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bmd_pkg.sv
design/bmd_front.sv
design/bmd_queue.sv
design/bmd_back.sv
design/binary_mask_dilation_unit.sv
design/bmd_checker.sv
tb/bmd_tb_pkg.sv
tb/bmd_dilation_checker.sv
tb/tb_binary_mask_dilation_unit.sv
